>>> hw/rtl/tcgw_pkg.sv
// ----------------------------------------------------------------------------
// tcgw_pkg: text console glyph writer shared definitions
// Field widths, control codes, register map and the command/status structs
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tcgw_pkg;

  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned GLYPH_GAP   = 1;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned FIDX_W   = 12;
  localparam int unsigned FBYTE_W  = 8;
  localparam int unsigned X_W      = 13;
  localparam int unsigned Y_W      = 12;
  localparam int unsigned SW_W     = 13;
  localparam int unsigned SH_W     = 13;
  localparam int unsigned PPL_W    = 14;
  localparam int unsigned OFF_W    = 25;
  localparam int unsigned BITS_W   = 8;
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 32;

  localparam logic [SW_W-1:0]  SW_RST  = SW_W'(640);
  localparam logic [SH_W-1:0]  SH_RST  = SH_W'(480);
  localparam logic [PPL_W-1:0] PPL_RST = PPL_W'(640);

  localparam logic [CODE_W-1:0] CHR_TAB = 8'd9;
  localparam logic [CODE_W-1:0] CHR_NL  = 8'd10;
  localparam logic [CODE_W-1:0] CHR_CR  = 8'd13;

  localparam logic [2:0] TAB_STEPS_M1 = 3'd7;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_FONT = 1'b1
  } op_e;

  typedef enum logic {
    KIND_ROW    = 1'b0,
    KIND_SCROLL = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH    = 2'd0,
    REG_SCREEN_HEIGHT   = 2'd1,
    REG_PIXELS_PER_LINE = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SW_W-1:0]  screen_width;
    logic [SH_W-1:0]  screen_height;
    logic [PPL_W-1:0] pixels_per_line;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [CODE_W-1:0]  char_code;
    logic [FIDX_W-1:0]  font_index;
    logic [FBYTE_W-1:0] font_byte;
  } in_item_t;

  typedef struct packed {
    logic font_we;
    logic load;
    logic cr;
    logic rd;
    logic base;
    logic gen_row;
    logic gen_scroll;
    logic col_step;
    logic line_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic can_gen;
    logic pend_v;
    logic col_wrap;
    logic line_fits;
  } sts_t;

endpackage

>>> hw/rtl/tcgw_if.sv
// ----------------------------------------------------------------------------
// tcgw_if: valid/ready channels of the text console glyph writer
// Input channel carries character and font-load words; output channel
// carries glyph-row writes and scroll commands.
// ----------------------------------------------------------------------------
interface tcgw_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  char_code;
  logic [11:0] font_index;
  logic [7:0]  font_byte;

  modport source (output valid, output op, output char_code, output font_index,
                  output font_byte, input ready);
  modport sink   (input valid, input op, input char_code, input font_index,
                  input font_byte, output ready);
endinterface

interface tcgw_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [24:0] pixel_offset;
  logic [7:0]  row_bits;
  logic        last;

  modport source (output valid, output kind, output pixel_offset, output row_bits,
                  output last, input ready);
  modport sink   (input valid, input kind, input pixel_offset, input row_bits,
                  input last, output ready);
endinterface

>>> hw/rtl/tcgw_ram.sv
// ----------------------------------------------------------------------------
// tcgw_ram: generic single-port RAM
// One address per cycle, write or read, registered read data held when idle.
// ----------------------------------------------------------------------------
module tcgw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tcgw_cfg.sv
// ----------------------------------------------------------------------------
// tcgw_cfg: configuration registers
// APB-style write/read of screen width, screen height and line stride.
// ----------------------------------------------------------------------------
module tcgw_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tcgw_pkg::APB_AW-1:0] paddr,
  input  logic [tcgw_pkg::APB_DW-1:0] pwdata,
  output logic [tcgw_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output tcgw_pkg::cfg_t             cfg_o
);
  import tcgw_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SCREEN_WIDTH:    cfg_d.screen_width    = pwdata[SW_W-1:0];
        REG_SCREEN_HEIGHT:   cfg_d.screen_height   = pwdata[SH_W-1:0];
        REG_PIXELS_PER_LINE: cfg_d.pixels_per_line = pwdata[PPL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCREEN_WIDTH:    prdata = APB_DW'(cfg_q.screen_width);
      REG_SCREEN_HEIGHT:   prdata = APB_DW'(cfg_q.screen_height);
      REG_PIXELS_PER_LINE: prdata = APB_DW'(cfg_q.pixels_per_line);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width    <= SW_RST;
      cfg_q.screen_height   <= SH_RST;
      cfg_q.pixels_per_line <= PPL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/tcgw_dp.sv
// ----------------------------------------------------------------------------
// tcgw_dp: glyph writer datapath
// Cursor, font store, offset accumulator, pending result and output register.
// ----------------------------------------------------------------------------
module tcgw_dp #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned FONT_BYTES   = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcgw_pkg::in_item_t            item_i,
  input  tcgw_pkg::cfg_t                cfg_i,
  input  tcgw_pkg::cmd_t                cmd_i,
  output tcgw_pkg::sts_t                sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [tcgw_pkg::OFF_W-1:0]    out_offset_o,
  output logic [tcgw_pkg::BITS_W-1:0]   out_bits_o,
  output logic                          out_last_o
);
  import tcgw_pkg::*;

  localparam int unsigned AW   = $clog2(FONT_BYTES);
  localparam int unsigned PW   = CODE_W + $clog2(GLYPH_HEIGHT);
  localparam int unsigned MW0  = (AW > PW) ? AW : PW;
  localparam int unsigned MW   = ((MW0 > FIDX_W) ? MW0 : FIDX_W) + 1;
  localparam int unsigned NSUB = ((1 << CODE_W) * GLYPH_HEIGHT - 1) / FONT_BYTES;
  localparam int unsigned CW   = X_W + 2;
  localparam int unsigned LW   = SH_W + 2;
  localparam int unsigned PRW  = Y_W + PPL_W;
  localparam logic [MW-1:0] FB_M   = MW'(FONT_BYTES);
  localparam logic [AW:0]   FB_A   = (AW + 1)'(FONT_BYTES);

  logic [X_W-1:0]    x_q, x_d;
  logic [Y_W-1:0]    y_q, y_d;
  logic [AW-1:0]     addr_q;
  logic [OFF_W-1:0]  off_q;
  logic              pend_v_q;
  logic              pend_kind_q;
  logic [OFF_W-1:0]  pend_off_q;
  logic [BITS_W-1:0] pend_bits_q;
  logic              o_v_q;
  logic              o_kind_q;
  logic [OFF_W-1:0]  o_off_q;
  logic [BITS_W-1:0] o_bits_q;
  logic              o_last_q;

  logic [MW-1:0]     base_m;
  logic [MW-1:0]     waddr_m;
  logic [AW:0]       addr_inc;
  logic [AW-1:0]     ram_addr;
  logic [BITS_W-1:0] rdata;
  logic [PRW-1:0]    prod;
  logic [OFF_W-1:0]  off_base;
  logic [CW-1:0]     x_lim, x_adv;
  logic [LW-1:0]     y_lim, y_adv;
  logic              col_wrap, line_fits;
  logic              gen, push;

  // glyph base address modulo font size
  always_comb begin
    base_m = MW'(item_i.char_code) * MW'(GLYPH_HEIGHT);
    for (int k = 0; k < NSUB; k++) begin
      if (base_m >= FB_M) begin
        base_m = base_m - FB_M;
      end
    end
    waddr_m = MW'(item_i.font_index);
    if (waddr_m >= FB_M) begin
      waddr_m = waddr_m - FB_M;
    end
  end

  assign addr_inc = {1'b0, addr_q} + (AW + 1)'(1);
  assign ram_addr = cmd_i.font_we ? waddr_m[AW-1:0] : addr_q;

  tcgw_ram #(
    .WIDTH (BITS_W),
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk_i   (clk_i),
    .we_i    (cmd_i.font_we),
    .re_i    (cmd_i.rd),
    .addr_i  (ram_addr),
    .wdata_i (item_i.font_byte),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= base_m[AW-1:0];
    end else if (cmd_i.rd) begin
      addr_q <= (addr_inc == FB_A) ? '0 : addr_inc[AW-1:0];
    end
  end

  assign prod     = PRW'(y_q) * PRW'(cfg_i.pixels_per_line);
  assign off_base = OFF_W'(prod + PRW'(x_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.base) begin
      off_q <= off_base;
    end else if (cmd_i.gen_row) begin
      off_q <= off_q + OFF_W'(cfg_i.pixels_per_line);
    end
  end

  // signed limits; a narrow screen wraps on every step
  assign x_lim     = CW'(cfg_i.screen_width) - CW'(GLYPH_WIDTH);
  assign x_adv     = CW'(x_q) + CW'(GLYPH_WIDTH + GLYPH_GAP);
  assign col_wrap  = $signed(x_adv) > $signed(x_lim);
  assign y_lim     = LW'(cfg_i.screen_height) - LW'(GLYPH_HEIGHT);
  assign y_adv     = LW'(y_q) + LW'(GLYPH_HEIGHT);
  assign line_fits = $signed(y_adv) <= $signed(y_lim);

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (cmd_i.cr) begin
      x_d = '0;
    end
    if (cmd_i.line_step || (cmd_i.col_step && col_wrap)) begin
      x_d = '0;
      if (line_fits) begin
        y_d = y_adv[Y_W-1:0];
      end
    end else if (cmd_i.col_step) begin
      x_d = x_adv[X_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // a result waits in the pending slot until the next one shows it was not last
  assign gen  = cmd_i.gen_row | cmd_i.gen_scroll;
  assign push = (gen & pend_v_q) | cmd_i.flush;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
      o_v_q    <= 1'b0;
    end else begin
      if (gen) begin
        pend_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
      end
      if (push) begin
        o_v_q <= 1'b1;
      end else if (out_ready_i) begin
        o_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (gen) begin
      pend_kind_q <= cmd_i.gen_scroll ? KIND_SCROLL : KIND_ROW;
      pend_off_q  <= cmd_i.gen_scroll ? '0 : off_q;
      pend_bits_q <= cmd_i.gen_scroll ? '0 : rdata;
    end
    if (push) begin
      o_kind_q <= pend_kind_q;
      o_off_q  <= pend_off_q;
      o_bits_q <= pend_bits_q;
      o_last_q <= cmd_i.flush;
    end
  end

  assign sts_o.can_gen   = ~pend_v_q | ~o_v_q | out_ready_i;
  assign sts_o.pend_v    = pend_v_q;
  assign sts_o.col_wrap  = col_wrap;
  assign sts_o.line_fits = line_fits;

  assign out_valid_o  = o_v_q;
  assign out_kind_o   = o_kind_q;
  assign out_offset_o = o_off_q;
  assign out_bits_o   = o_bits_q;
  assign out_last_o   = o_last_q;

endmodule

>>> hw/rtl/tcgw_ctrl.sv
// ----------------------------------------------------------------------------
// tcgw_ctrl: glyph writer controller
// Decodes each input word and sequences glyph rows, column and line steps.
// ----------------------------------------------------------------------------
module tcgw_ctrl #(
  parameter int unsigned GLYPH_HEIGHT = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcgw_pkg::in_item_t item_i,
  input  tcgw_pkg::sts_t     sts_i,
  output tcgw_pkg::cmd_t     cmd_o
);
  import tcgw_pkg::*;

  localparam int unsigned RW = $clog2(GLYPH_HEIGHT);
  localparam logic [RW-1:0] ROW_LAST = RW'(GLYPH_HEIGHT - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_ROW   = 6'b000100,
    S_COL   = 6'b001000,
    S_LINE  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [RW-1:0] row_q, row_d;
  logic [2:0]    left_q, left_d;
  logic          accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    left_d  = left_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.op == OP_FONT) begin
            cmd_o.font_we = 1'b1;
          end else if (item_i.char_code == CHR_CR) begin
            cmd_o.cr = 1'b1;
          end else if (item_i.char_code == CHR_TAB) begin
            left_d  = TAB_STEPS_M1;
            state_d = S_COL;
          end else if (item_i.char_code == CHR_NL) begin
            state_d = S_LINE;
          end else begin
            cmd_o.load = 1'b1;
            left_d     = '0;
            state_d    = S_ISSUE;
          end
        end
      end
      S_ISSUE: begin
        cmd_o.rd   = 1'b1;
        cmd_o.base = 1'b1;
        row_d      = '0;
        state_d    = S_ROW;
      end
      S_ROW: begin
        if (sts_i.can_gen) begin
          cmd_o.gen_row = 1'b1;
          if (row_q == ROW_LAST) begin
            state_d = S_COL;
          end else begin
            cmd_o.rd = 1'b1;
            row_d    = row_q + RW'(1);
          end
        end
      end
      S_COL: begin
        if (!(sts_i.col_wrap && !sts_i.line_fits) || sts_i.can_gen) begin
          cmd_o.col_step   = 1'b1;
          cmd_o.gen_scroll = sts_i.col_wrap & ~sts_i.line_fits;
          if (left_q == '0) begin
            state_d = S_FLUSH;
          end else begin
            left_d = left_q - 3'd1;
          end
        end
      end
      S_LINE: begin
        if (sts_i.line_fits || sts_i.can_gen) begin
          cmd_o.line_step  = 1'b1;
          cmd_o.gen_scroll = ~sts_i.line_fits;
          state_d          = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_v) begin
          state_d = S_IDLE;
        end else if (sts_i.can_gen) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q   <= '0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      left_q  <= left_d;
    end
  end

endmodule

>>> hw/rtl/text_console_glyph_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_glyph_writer_top: 8-pixel-wide framebuffer text console
// Turns character words into glyph-row writes and scroll commands, with a
// font store loaded by font words.
//
//   channel  dir  handshake        word
//   in_i     in   valid/ready      op, char_code, font_index, font_byte
//   out_o    out  valid/ready      kind, pixel_offset, row_bits, last
//   apb      in   psel/penable     screen_width @0, screen_height @4,
//                                  pixels_per_line @8
//
// Printable code: accept, font read issue, one row a cycle from the single
// font store port unless the output stalls, column step, final flush. Tab:
// eight column steps, flush. Newline: line step, flush. Font word, CR: accept.
// One word at a time; the last result is held back until the word ends, so
// a slow sink stalls the row sequence, never the result order.
// Reset gives cursor zero and default geometry; the font store is not cleared.
// ----------------------------------------------------------------------------
module text_console_glyph_writer_top #(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned FONT_BYTES   = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tcgw_in_if.sink                     in_i,
  tcgw_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tcgw_pkg::APB_AW-1:0] paddr,
  input  logic [tcgw_pkg::APB_DW-1:0] pwdata,
  output logic [tcgw_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import tcgw_pkg::*;

  in_item_t item;
  cfg_t     cfg;
  cmd_t     cmd;
  sts_t     sts;
  logic     in_ready;

  assign item.op         = in_i.op;
  assign item.char_code  = in_i.char_code;
  assign item.font_index = in_i.font_index;
  assign item.font_byte  = in_i.font_byte;
  assign in_i.ready      = in_ready;

  tcgw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tcgw_ctrl #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .item_i     (item),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tcgw_dp #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .FONT_BYTES   (FONT_BYTES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_kind_o   (out_o.kind),
    .out_offset_o (out_o.pixel_offset),
    .out_bits_o   (out_o.row_bits),
    .out_last_o   (out_o.last)
  );

endmodule

>>> tb/tb_text_console_glyph_writer_top.sv
// ----------------------------------------------------------------------------
// tb_text_console_glyph_writer_top: self-checking bench for the glyph writer
// Loads glyphs into the font store, then walks a short directed table of
// character and font words with register writes between them, followed by
// random traffic under several screen geometries. A behavioural model of the
// console cursor, font store and wrap/scroll rules predicts every glyph-row
// write and scroll; a scoreboard checks the output channel in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_glyph_writer_top;
  import tcgw_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int GLYPH_H      = 16;
  localparam int FONT_SZ      = 4096;
  localparam int GLYPH_W_PX   = GLYPH_WIDTH;
  localparam int GAP_PX       = GLYPH_GAP;
  localparam int X_MASK       = (1 << X_W) - 1;
  localparam int Y_MASK       = (1 << Y_W) - 1;
  localparam int DRAIN_CYCLES = 2 * (GLYPH_H + 4);
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_REPORTS  = 10;
  localparam int UNTYPED      = -1;
  localparam logic [APB_AW-1:0] ADDR_SPARE = 4'hC;
  localparam logic [CODE_W-1:0] PRELOAD[9] =
    '{8'h00, 8'h08, 8'h0B, 8'h0C, 8'h0E, 8'h41, 8'h7F, 8'h80, 8'hFF};

  typedef struct packed {
    kind_e              kind;
    logic [OFF_W-1:0]   offset;
    logic [BITS_W-1:0]  bits;
    logic               last;
  } fb_write_t;

  typedef enum logic [1:0] {
    STEP_FONT,
    STEP_CHAR,
    STEP_CFG
  } step_e;

  typedef struct {
    step_e step;
    int    a;
    int    b;
    int    n_typed;
    kind_e kind;
    int    offset;
    int    bits;
  } stim_row_t;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_PATTERN
  } sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  tcgw_in_if  in_bus ();
  tcgw_out_if out_bus ();

  // console model state
  int        scr_w;
  int        scr_h;
  int        stride;
  int        cur_x;
  int        cur_y;
  logic [7:0] font_mem[FONT_SZ];
  bit        font_set[FONT_SZ];
  bit        glyph_ready[FONT_SZ / GLYPH_H];
  logic [CODE_W-1:0] drawable_codes[$];

  fb_write_t word_results[$];
  fb_write_t fb_writes_due[$];
  stim_row_t stim_rows[$];

  int  err_cnt = 0;
  int  words_sent = 0;
  int  burst_left;
  bit  gaps_on;
  bit  hold_req;
  logic sink_hold;
  int  cycle_cnt;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  text_console_glyph_writer_top #(
    .GLYPH_HEIGHT(GLYPH_H),
    .FONT_BYTES  (FONT_SZ)
  ) dut (
    .clk_i,
    .rst_ni,
    .in_i   (in_bus),
    .out_o  (out_bus),
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  // ---- console model --------------------------------------------------------

  task automatic line_step();
    fb_write_t sc;
    cur_x = 0;
    if (cur_y + GLYPH_H <= scr_h - GLYPH_H) begin
      cur_y = (cur_y + GLYPH_H) & Y_MASK;
    end else begin
      sc = '0;
      sc.kind = KIND_SCROLL;
      word_results.push_back(sc);
    end
  endtask

  task automatic column_step();
    int limit;
    limit = scr_w - GLYPH_W_PX;
    cur_x += GLYPH_W_PX;
    if (cur_x <= limit) cur_x += GAP_PX;
    if (cur_x > limit) line_step();
    cur_x &= X_MASK;
  endtask

  task automatic predict_console(input in_item_t w, output int n_out,
                                 output fb_write_t first_out);
    fb_write_t rw;
    longint    row_off;
    int        fidx;
    int        g;
    bit        full;
    word_results = {};
    if (w.op == OP_FONT) begin
      fidx = int'(w.font_index) % FONT_SZ;
      font_mem[fidx] = w.font_byte;
      font_set[fidx] = 1'b1;
      g = fidx / GLYPH_H;
      full = 1'b1;
      for (int r = 0; r < GLYPH_H; r++) full &= font_set[g * GLYPH_H + r];
      if (full && !glyph_ready[g] && g != CHR_CR && g != CHR_TAB && g != CHR_NL) begin
        glyph_ready[g] = 1'b1;
        drawable_codes.push_back(CODE_W'(g));
      end
    end else if (w.char_code == CHR_CR) begin
      cur_x = 0;
    end else if (w.char_code == CHR_TAB) begin
      repeat (int'(TAB_STEPS_M1) + 1) column_step();
    end else if (w.char_code == CHR_NL) begin
      line_step();
    end else begin
      for (int r = 0; r < GLYPH_H; r++) begin
        row_off = longint'(cur_x) + (longint'(cur_y) + r) * longint'(stride);
        rw.kind   = KIND_ROW;
        rw.offset = row_off[OFF_W-1:0];
        rw.bits   = font_mem[(int'(w.char_code) * GLYPH_H + r) % FONT_SZ];
        rw.last   = 1'b0;
        word_results.push_back(rw);
      end
      column_step();
    end
    if (word_results.size() > 0) word_results[$].last = 1'b1;
    n_out = word_results.size();
    first_out = (n_out > 0) ? word_results[0] : '0;
    foreach (word_results[i]) fb_writes_due.push_back(word_results[i]);
  endtask

  // ---- drivers --------------------------------------------------------------

  task automatic send_word(input in_item_t w, output int n_out, output fb_write_t first_out);
    int gap;
    in_bus.valid      <= 1'b1;
    in_bus.op         <= w.op;
    in_bus.char_code  <= w.char_code;
    in_bus.font_index <= w.font_index;
    in_bus.font_byte  <= w.font_byte;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    predict_console(w, n_out, first_out);
    words_sent++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  function automatic in_item_t noise_word();
    in_item_t w;
    w.op         = OP_CHAR;
    w.char_code  = CODE_W'($urandom);
    w.font_index = FIDX_W'($urandom);
    w.font_byte  = FBYTE_W'($urandom);
    return w;
  endfunction

  task automatic load_glyph(input logic [CODE_W-1:0] code);
    in_item_t  w;
    int        n;
    fb_write_t f;
    for (int r = 0; r < GLYPH_H; r++) begin
      w = noise_word();
      w.op = OP_FONT;
      w.font_index = FIDX_W'(int'(code) * GLYPH_H + r);
      send_word(w, n, f);
    end
  endtask

  task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    if (addr[1:0] == 2'b00) begin
      case (addr[3:2])
        REG_SCREEN_WIDTH:    scr_w  = int'(data) & ((1 << SW_W) - 1);
        REG_SCREEN_HEIGHT:   scr_h  = int'(data) & ((1 << SH_W) - 1);
        REG_PIXELS_PER_LINE: stride = int'(data) & ((1 << PPL_W) - 1);
        default: ;
      endcase
    end
  endtask

  function automatic logic [APB_AW-1:0] reg_addr(input reg_idx_e r);
    return {r, 2'b00};
  endfunction

  // block finished with every word, including ones that emit nothing
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (fb_writes_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int w_px, input int h_px, input int ppl);
    wait_idle();
    write_reg(reg_addr(REG_SCREEN_WIDTH), APB_DW'(w_px));
    write_reg(reg_addr(REG_SCREEN_HEIGHT), APB_DW'(h_px));
    write_reg(reg_addr(REG_PIXELS_PER_LINE), APB_DW'(ppl));
  endtask

  // printable, control and font words; whole-glyph loads grow the drawable set
  task automatic run_random(input int n_words, input int tab_pct);
    in_item_t  w;
    int        n;
    fb_write_t f;
    int        pick;
    int        start;
    start = words_sent;
    while (words_sent - start < n_words) begin
      pick = $urandom_range(0, 99);
      w = noise_word();
      if (pick < 3) begin
        load_glyph(CODE_W'($urandom));
      end else begin
        if (pick < 6) begin
          w.op = OP_FONT;
        end else if (pick < 14) begin
          w.char_code = CHR_CR;
        end else if (pick < 14 + tab_pct) begin
          w.char_code = CHR_TAB;
        end else if (pick < 26 + tab_pct) begin
          w.char_code = CHR_NL;
        end else begin
          w.char_code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
        end
        send_word(w, n, f);
      end
    end
  endtask

  function automatic void add_row(input step_e s, input int a, input int b, input int n,
                                  input kind_e k = KIND_ROW, input int off = 0,
                                  input int bits = 0);
    stim_row_t row;
    row.step    = s;
    row.a       = a;
    row.b       = b;
    row.n_typed = n;
    row.kind    = k;
    row.offset  = off;
    row.bits    = bits;
    stim_rows.push_back(row);
  endfunction

  // ---- receiver and scoreboard ------------------------------------------------

  initial begin : hold_off
    int hold_cnt;
    sink_hold = 1'b0;
    wait (hold_req);
    @(posedge clk_i);
    sink_hold <= 1'b1;
    for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
    sink_hold <= 1'b0;
  end

  initial begin : fb_sink
    fb_write_t  got;
    fb_write_t  want;
    sink_mode_e mode;
    int         left;
    logic [7:0] pat;
    out_bus.ready = 1'b0;
    mode = SINK_OPEN;
    left = 0;
    pat  = 8'hFF;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready) begin
        got.kind   = kind_e'(out_bus.kind);
        got.offset = out_bus.pixel_offset;
        got.bits   = out_bus.row_bits;
        got.last   = out_bus.last;
        if (fb_writes_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("unexpected write: kind %0d off %0d bits %02h last %0b",
                     got.kind, got.offset, got.bits, got.last);
        end else begin
          want = fb_writes_due.pop_front();
          if (got.kind !== want.kind || got.offset !== want.offset ||
              got.bits !== want.bits || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $write("write mismatch: want kind %0d off %0d bits %02h last %0b, ",
                     want.kind, want.offset, want.bits, want.last);
              $display("got kind %0d off %0d bits %02h last %0b",
                       got.kind, got.offset, got.bits, got.last);
            end
          end
        end
      end
      if (left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 2));
        left = $urandom_range(16, 150);
        pat  = 8'($urandom) | 8'h01;
      end
      left--;
      if (sink_hold) begin
        out_bus.ready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   out_bus.ready <= 1'b1;
          SINK_RANDOM: out_bus.ready <= ($urandom_range(0, 2) != 0);
          default: begin
            out_bus.ready <= pat[0];
            pat = {pat[0], pat[7:1]};
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("text_console_glyph_writer_top verification failed");
    $finish;
  end

  // ---- stimulus ---------------------------------------------------------------

  initial begin : stimulus
    in_item_t  w;
    int        n;
    fb_write_t f;
    stim_row_t row;

    rst_ni            = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.op         = OP_CHAR;
    in_bus.char_code  = '0;
    in_bus.font_index = '0;
    in_bus.font_byte  = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    hold_req          = 1'b0;
    gaps_on           = 1'b1;
    burst_left        = $urandom_range(1, 12);
    scr_w             = int'(SW_RST);
    scr_h             = int'(SH_RST);
    stride            = int'(PPL_RST);
    cur_x             = 0;
    cur_y             = 0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (PRELOAD[i]) load_glyph(PRELOAD[i]);

    // default geometry, cursor at origin
    add_row(STEP_FONT, 'h410, 'h81, 0);
    add_row(STEP_FONT, 'hFF0, 'hFF, 0);
    add_row(STEP_FONT, 'h000, 'h00, 0);
    add_row(STEP_CHAR, 'h41, 0, 16, KIND_ROW, 0, 'h81);
    add_row(STEP_CHAR, 'hFF, 0, 16, KIND_ROW, 9, 'hFF);
    add_row(STEP_CHAR, 'h00, 0, 16, KIND_ROW, 18, 'h00);
    add_row(STEP_CHAR, CHR_CR, 0, 0);
    add_row(STEP_CHAR, CHR_TAB, 0, 0);
    add_row(STEP_CHAR, CHR_NL, 0, 0);
    add_row(STEP_CHAR, 'h80, 0, UNTYPED);
    add_row(STEP_CHAR, 'h7F, 0, UNTYPED);
    add_row(STEP_CHAR, 'h08, 0, UNTYPED);
    add_row(STEP_CHAR, 'h0B, 0, UNTYPED);
    add_row(STEP_CHAR, 'h0C, 0, UNTYPED);
    add_row(STEP_CHAR, 'h0E, 0, UNTYPED);
    // three text lines: second newline hits the bottom
    add_row(STEP_CFG, reg_addr(REG_SCREEN_HEIGHT), 48, UNTYPED);
    add_row(STEP_CHAR, CHR_NL, 0, 0);
    add_row(STEP_CHAR, CHR_NL, 0, 1, KIND_SCROLL, 0, 0);
    // one-column screen: every column step wraps and scrolls
    add_row(STEP_CFG, reg_addr(REG_SCREEN_WIDTH), 8, UNTYPED);
    add_row(STEP_CHAR, CHR_TAB, 0, 8, KIND_SCROLL, 0, 0);
    add_row(STEP_CHAR, 'h41, 0, 17, KIND_ROW, 32 * 640, 'h81);
    add_row(STEP_CFG, reg_addr(REG_PIXELS_PER_LINE), 8192, UNTYPED);
    add_row(STEP_CHAR, 'hFF, 0, 17, KIND_ROW, 32 * 8192, 'hFF);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.step == STEP_CFG) begin
        wait_idle();
        write_reg(row.a[APB_AW-1:0], APB_DW'(row.b));
      end else begin
        w = noise_word();
        if (row.step == STEP_FONT) begin
          w.op         = OP_FONT;
          w.font_index = row.a[FIDX_W-1:0];
          w.font_byte  = row.b[FBYTE_W-1:0];
        end else begin
          w.char_code = row.a[CODE_W-1:0];
        end
        send_word(w, n, f);
        if (row.n_typed != UNTYPED &&
            (n != row.n_typed || (n > 0 && (f.kind !== row.kind ||
             f.offset !== OFF_W'(row.offset) || f.bits !== BITS_W'(row.bits))))) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $write("row %0d: %0d writes, first kind %0d off %0d bits %02h; ",
                   i, n, f.kind, f.offset, f.bits);
            $display("want %0d, %0d %0d %02h",
                     row.n_typed, row.kind, row.offset, row.bits);
          end
        end
      end
    end

    // back to defaults; long sink hold-off while words keep coming
    set_geometry(int'(SW_RST), int'(SH_RST), int'(PPL_RST));
    run_random(10, 10);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    run_random(20, 10);
    gaps_on  = 1'b1;

    set_geometry(8, 16, 8);
    run_random(15, 10);

    set_geometry(4096, 4096, 8192);
    gaps_on = 1'b0;
    run_random(15, 10);
    gaps_on = 1'b1;

    // tall screen, widest stride: tabs walk cursor_y round and offsets wrap
    set_geometry(8, 8191, 16383);
    run_random(70, 45);

    set_geometry(8191, $urandom_range(16, 4096), $urandom_range(8, 8192));
    write_reg(ADDR_SPARE, APB_DW'($urandom));
    run_random(10, 10);

    wait_idle();
    if (err_cnt == 0 && fb_writes_due.size() == 0) begin
      $display("text_console_glyph_writer_top verification clean");
    end else begin
      $display("text_console_glyph_writer_top verification failed");
    end
    $finish;
  end

endmodule
